// File: rtl/ssp_pkg.sv
package ssp_pkg;

  localparam int PULSE_BITS_DEF      = 12;
  localparam int SPEED_FRAC_BITS_DEF = 14;
  localparam int SPEED_W             = 16;

  // operation codes
  localparam logic [1:0] OP_SET  = 2'd0;
  localparam logic [1:0] OP_STOP = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // register indexes
  localparam logic [2:0] REG_MAX     = 3'd0;
  localparam logic [2:0] REG_DB_HIGH = 3'd1;
  localparam logic [2:0] REG_CENTER  = 3'd2;
  localparam logic [2:0] REG_DB_LOW  = 3'd3;
  localparam logic [2:0] REG_MIN     = 3'd4;
  localparam logic [2:0] REG_INVERT  = 3'd5;
  localparam logic [2:0] REG_SKIP_DB = 3'd6;

  // register reset values, microseconds
  localparam int MAX_RST     = 2000;
  localparam int DB_HIGH_RST = 1510;
  localparam int CENTER_RST  = 1500;
  localparam int DB_LOW_RST  = 1490;
  localparam int MIN_RST     = 1000;

endpackage

// File: rtl/ssp_front.sv
module ssp_front import ssp_pkg::*; #(
  parameter int PULSE_BITS      = PULSE_BITS_DEF,
  parameter int SPEED_FRAC_BITS = SPEED_FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   op_i,
  input  logic signed [SPEED_W-1:0]    speed_i,
  input  logic                         invalid_i,
  input  logic [PULSE_BITS-1:0]        max_i,
  input  logic [PULSE_BITS-1:0]        min_i,
  input  logic [PULSE_BITS-1:0]        center_i,
  input  logic signed [PULSE_BITS+1:0] fwd_i,
  input  logic signed [PULSE_BITS+1:0] rev_i,
  input  logic                         inv_i,
  input  logic                         full_i,
  output logic                         push_o,
  output logic [PULSE_BITS-1:0]        push_data_o
);

  localparam int EW  = PULSE_BITS + 2;
  localparam int SW2 = SPEED_FRAC_BITS + 2;
  localparam int CW  = (SPEED_W + 1 > SW2) ? SPEED_W + 1 : SW2;
  localparam int PW  = SW2 + EW;
  localparam int QW  = PW - SPEED_FRAC_BITS;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_FIN  = 2'd2;

  localparam logic signed [CW-1:0] ONE_C =
    {{(CW-SPEED_FRAC_BITS-1){1'b0}}, 1'b1, {SPEED_FRAC_BITS{1'b0}}};
  localparam logic [PW-1:0] HALF_C =
    {{(PW-SPEED_FRAC_BITS){1'b0}}, 1'b1, {(SPEED_FRAC_BITS-1){1'b0}}};
  localparam logic signed [QW-1:0] PMAX_C =
    {{(QW-PULSE_BITS){1'b0}}, {PULSE_BITS{1'b1}}};

  logic [1:0]                 state_q, state_d;
  logic [1:0]                 op_q;
  logic                       zero_q;
  logic signed [SW2-1:0]      s_q;
  logic signed [EW-1:0]       d_q, edge_q;
  logic signed [PW-1:0]       prod_q;
  logic [PULSE_BITS-1:0]      held_q;

  logic signed [CW-1:0]       s_ext, s_neg, s_clamp;
  logic signed [EW-1:0]       max_s, min_s, d_c, edge_c;
  logic [PW-1:0]              mag, mag_rnd;
  logic signed [QW-1:0]       q_s, p_full;
  logic [PULSE_BITS-1:0]      p_sat, p_new;
  logic                       accept;

  assign in_ready_o = (state_q == F_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    s_ext = {{(CW-SPEED_W){speed_i[SPEED_W-1]}}, speed_i};
    s_neg = inv_i ? -s_ext : s_ext;
    if (invalid_i) begin
      s_clamp = '0;
    end else if (s_neg > ONE_C) begin
      s_clamp = ONE_C;
    end else if (s_neg < -ONE_C) begin
      s_clamp = -ONE_C;
    end else begin
      s_clamp = s_neg;
    end
    max_s = $signed({2'b00, max_i});
    min_s = $signed({2'b00, min_i});
    if (s_clamp > 0) begin
      d_c    = max_s - fwd_i;
      edge_c = fwd_i;
    end else begin
      d_c    = rev_i - min_s;
      edge_c = rev_i;
    end
  end

  // round half away from zero on the magnitude, add the edge, clamp to the pulse range, then pick by op
  always_comb begin
    mag     = prod_q[PW-1] ? $unsigned(-prod_q) : $unsigned(prod_q);
    mag_rnd = mag + HALF_C;
    q_s     = $signed(mag_rnd[PW-1:SPEED_FRAC_BITS]);
    if (prod_q[PW-1]) begin
      q_s = -q_s;
    end
    p_full = q_s + {{(QW-EW){edge_q[EW-1]}}, edge_q};
    if (p_full < 0) begin
      p_sat = '0;
    end else if (p_full > PMAX_C) begin
      p_sat = PMAX_C[PULSE_BITS-1:0];
    end else begin
      p_sat = p_full[PULSE_BITS-1:0];
    end
    case (op_q)
      OP_SET:  p_new = zero_q ? center_i : p_sat;
      OP_STOP: p_new = '0;
      default: p_new = held_q;
    endcase
  end

  always_comb begin
    state_d = state_q;
    push_o  = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          state_d = F_MUL;
        end
      end
      F_MUL: begin
        state_d = F_FIN;
      end
      F_FIN: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign push_data_o = p_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      held_q  <= '0;
    end else begin
      state_q <= state_d;
      if (push_o) begin
        held_q <= p_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_i;
      zero_q <= (s_clamp == '0);
      s_q    <= s_clamp[SW2-1:0];
      d_q    <= d_c;
      edge_q <= edge_c;
    end
    if (state_q == F_MUL) begin
      prod_q <= s_q * d_q;
    end
  end

endmodule

// File: rtl/ssp_queue.sv
module ssp_queue import ssp_pkg::*; #(
  parameter int PULSE_BITS = PULSE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [PULSE_BITS-1:0] push_data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output logic [PULSE_BITS-1:0] pop_data_o
);

  logic [PULSE_BITS-1:0] slot_q [2];
  logic                  wr_ptr_q, rd_ptr_q;
  logic [1:0]            count_q;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_data_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/ssp_back.sv
module ssp_back import ssp_pkg::*; #(
  parameter int PULSE_BITS      = PULSE_BITS_DEF,
  parameter int SPEED_FRAC_BITS = SPEED_FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         empty_i,
  input  logic [PULSE_BITS-1:0]        pop_data_i,
  output logic                         pop_o,
  input  logic [PULSE_BITS-1:0]        max_i,
  input  logic [PULSE_BITS-1:0]        min_i,
  input  logic signed [PULSE_BITS+1:0] fwd_i,
  input  logic signed [PULSE_BITS+1:0] rev_i,
  input  logic                         inv_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [PULSE_BITS-1:0]        out_pulse_o,
  output logic signed [SPEED_W-1:0]    out_speed_o
);

  localparam int EW  = PULSE_BITS + 2;
  localparam int QW  = SPEED_FRAC_BITS + 1;
  localparam int NW  = SPEED_FRAC_BITS + 2;
  localparam int RW  = (NW > SPEED_W + 1) ? NW : SPEED_W + 1;
  localparam int CNW = $clog2(QW + 1);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_DIV  = 2'd1;
  localparam logic [1:0] B_DONE = 2'd2;

  localparam logic [QW-1:0]  ONE_Q   = {1'b1, {SPEED_FRAC_BITS{1'b0}}};
  localparam logic [CNW-1:0] STEPS_C = CNW'(QW);
  localparam logic signed [RW-1:0] SMAX_C =
    {{(RW-SPEED_W+1){1'b0}}, {(SPEED_W-1){1'b1}}};
  localparam logic signed [RW-1:0] SMIN_C =
    {{(RW-SPEED_W+1){1'b1}}, {(SPEED_W-1){1'b0}}};

  logic [1:0]              state_q, state_d;
  logic [PULSE_BITS-1:0]   pulse_q;
  logic [PULSE_BITS:0]     rem_q;
  logic [PULSE_BITS-1:0]   den_q;
  logic [QW-1:0]           quo_q;
  logic                    neg_q;
  logic [CNW-1:0]          cnt_q;
  logic                    out_valid_q;
  logic [PULSE_BITS-1:0]   out_pulse_q;
  logic signed [SPEED_W-1:0] out_speed_q;

  logic signed [EW-1:0]    p_s, max_s, min_s, num_f, num_r, den_f, den_r;
  logic                    take_bit;
  logic [PULSE_BITS:0]     rem_sub;
  logic signed [RW-1:0]    rb_val;
  logic signed [SPEED_W-1:0] rb_sat;
  logic                    out_free;

  assign p_s   = $signed({2'b00, pop_data_i});
  assign max_s = $signed({2'b00, max_i});
  assign min_s = $signed({2'b00, min_i});
  assign num_f = p_s - fwd_i;
  assign den_f = max_s - fwd_i;
  assign num_r = rev_i - p_s;
  assign den_r = rev_i - min_s;

  assign pop_o    = (state_q == B_IDLE) && !empty_i;
  assign out_free = !out_valid_q || out_ready_i;

  // one quotient bit a cycle; the remainder stays below twice the divisor
  assign take_bit = (rem_q >= {1'b0, den_q});
  assign rem_sub  = take_bit ? rem_q - {1'b0, den_q} : rem_q;

  always_comb begin
    rb_val = {{(RW-QW){1'b0}}, quo_q};
    if (neg_q ^ inv_i) begin
      rb_val = -rb_val;
    end
    if (rb_val > SMAX_C) begin
      rb_sat = SMAX_C[SPEED_W-1:0];
    end else if (rb_val < SMIN_C) begin
      rb_sat = SMIN_C[SPEED_W-1:0];
    end else begin
      rb_sat = rb_val[SPEED_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (pop_o) begin
          if (pop_data_i != '0 && !(p_s > max_s) && !(p_s < min_s) &&
              ((p_s > fwd_i) || (p_s < rev_i))) begin
            state_d = B_DIV;
          end else begin
            state_d = B_DONE;
          end
        end
      end
      B_DIV: begin
        if (cnt_q == STEPS_C) begin
          state_d = B_DONE;
        end
      end
      B_DONE: begin
        if (out_free) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pulse_q <= pop_data_i;
      cnt_q   <= '0;
      quo_q   <= '0;
      neg_q   <= 1'b0;
      rem_q   <= '0;
      den_q   <= '0;
      if (pop_data_i == '0) begin
        quo_q <= '0;
      end else if (p_s > max_s) begin
        quo_q <= ONE_Q;
      end else if (p_s < min_s) begin
        quo_q <= ONE_Q;
        neg_q <= 1'b1;
      end else if (p_s > fwd_i) begin
        rem_q <= {1'b0, num_f[PULSE_BITS-1:0]};
        den_q <= den_f[PULSE_BITS-1:0];
      end else if (p_s < rev_i) begin
        rem_q <= {1'b0, num_r[PULSE_BITS-1:0]};
        den_q <= den_r[PULSE_BITS-1:0];
        neg_q <= 1'b1;
      end
    end else if (state_q == B_DIV && cnt_q != STEPS_C) begin
      quo_q <= {quo_q[QW-2:0], take_bit};
      rem_q <= {rem_sub[PULSE_BITS-1:0], 1'b0};
      cnt_q <= cnt_q + CNW'(1);
    end
    if (state_q == B_DONE && out_free) begin
      out_pulse_q <= pulse_q;
      out_speed_q <= rb_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pulse_o = out_pulse_q;
  assign out_speed_o = out_speed_q;

endmodule

// File: rtl/speed_to_servo_pulse_mapper.sv
// Speed to servo pulse mapper.
// Input stream: one request per item. tuser carries the operation (set speed,
// stop, read only) and the invalid flag; tdata carries the signed speed
// command in Q.SPEED_FRAC_BITS. A set request clamps the speed, maps it to a
// pulse width and holds it; stop holds a zero pulse; read leaves it alone.
// Output stream: one result per request with the held pulse width and the
// speed recovered from it, in request order.
// The front end takes a request through accept, multiply and round, then
// pushes it into the queue. When the readback needs a division the back end
// pops the entry, runs the divider and then loads the output register, which
// raises tvalid; without a division it pops and loads the output register.
// The front end takes a new request only once it has pushed the last one; the
// back end works on one entry at a time, so when every readback divides the
// divider sets the sustained rate, and otherwise the front end sets it.
// A two-entry queue sits between front and back end, and the result sits in
// an output register, so new requests are taken while a result waits.
// When the receiver stalls, the result holds, the queue fills and tready
// drops. Reset clears the held pulse to zero (stopped), empties the pipeline
// and loads the default pulse bounds. Write the registers only while idle.
module speed_to_servo_pulse_mapper import ssp_pkg::*; #(
  parameter int PULSE_BITS      = PULSE_BITS_DEF,
  parameter int SPEED_FRAC_BITS = SPEED_FRAC_BITS_DEF,
  parameter int OUT_W           = ((PULSE_BITS + SPEED_W + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [SPEED_W-1:0]    s_axis_tdata,   // speed_cmd
  input  logic [2:0]            s_axis_tuser,   // operation[1:0], speed_invalid
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata,   // pulse_us, speed_readback, zero pad
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [PULSE_BITS-1:0] cfg_data_i
);

  localparam logic signed [PULSE_BITS+1:0] ONE_US = (PULSE_BITS+2)'(1);

  logic [PULSE_BITS-1:0]        max_q, db_high_q, center_q, db_low_q, min_q;
  logic                         inv_q, skip_q;
  logic signed [PULSE_BITS+1:0] fwd_edge, rev_edge;

  logic                         push, full, pop, empty;
  logic [PULSE_BITS-1:0]        push_data, pop_data, out_pulse;
  logic signed [SPEED_W-1:0]    out_speed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q     <= PULSE_BITS'(MAX_RST);
      db_high_q <= PULSE_BITS'(DB_HIGH_RST);
      center_q  <= PULSE_BITS'(CENTER_RST);
      db_low_q  <= PULSE_BITS'(DB_LOW_RST);
      min_q     <= PULSE_BITS'(MIN_RST);
      inv_q     <= 1'b0;
      skip_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAX:     max_q     <= cfg_data_i;
        REG_DB_HIGH: db_high_q <= cfg_data_i;
        REG_CENTER:  center_q  <= cfg_data_i;
        REG_DB_LOW:  db_low_q  <= cfg_data_i;
        REG_MIN:     min_q     <= cfg_data_i;
        REG_INVERT:  inv_q     <= cfg_data_i[0];
        REG_SKIP_DB: skip_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // without deadband elimination the edges sit one microsecond off center
  assign fwd_edge = skip_q ? $signed({2'b00, db_high_q})
                           : $signed({2'b00, center_q}) + ONE_US;
  assign rev_edge = skip_q ? $signed({2'b00, db_low_q})
                           : $signed({2'b00, center_q}) - ONE_US;

  ssp_front #(
    .PULSE_BITS      (PULSE_BITS),
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tuser[1:0]),
    .speed_i     ($signed(s_axis_tdata)),
    .invalid_i   (s_axis_tuser[2]),
    .max_i       (max_q),
    .min_i       (min_q),
    .center_i    (center_q),
    .fwd_i       (fwd_edge),
    .rev_i       (rev_edge),
    .inv_i       (inv_q),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  ssp_queue #(
    .PULSE_BITS (PULSE_BITS)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  ssp_back #(
    .PULSE_BITS      (PULSE_BITS),
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .max_i       (max_q),
    .min_i       (min_q),
    .fwd_i       (fwd_edge),
    .rev_i       (rev_edge),
    .inv_i       (inv_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pulse_o (out_pulse),
    .out_speed_o (out_speed)
  );

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[PULSE_BITS-1:0]                  = out_pulse;
    m_axis_tdata[PULSE_BITS+SPEED_W-1:PULSE_BITS] = out_speed;
  end

endmodule
